// ===== sv/info_frame_byte_stuffer_macros.svh =====
// ----------------------------------------------------------------------------
// info_frame_byte_stuffer assertion macros
// Shorthand for clocked assertions with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef INFO_FRAME_BYTE_STUFFER_MACROS_SVH
`define INFO_FRAME_BYTE_STUFFER_MACROS_SVH

// antecedent and consequent checked at the same edge
`define IFBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked at the edge after the antecedent
`define IFBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ifbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ifbs_pkg
// Types and constants shared by the information frame byte stuffer.
// ----------------------------------------------------------------------------
package ifbs_pkg;

   localparam logic [7:0] FLAG_BYTE  = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_MASK   = 8'h20;
   localparam logic [7:0] CTRL_SEQ0  = 8'h00;
   localparam logic [7:0] CTRL_SEQ1  = 8'h40;
   localparam logic [7:0] ADDR_RESET = 8'h03;

   // one classified input word, as handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       hdr;    // word opens a frame
      logic [7:0] ctrl;
      logic [7:0] addr;
      logic       last;
      logic [7:0] bcc;    // BCC2 of the frame so far, including data
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

   typedef enum logic [3:0] {
      PH_START,
      PH_FLAG,
      PH_ADDR,
      PH_CTRL,
      PH_BCC1,
      PH_DATA_ESC,
      PH_DATA,
      PH_BCC2_ESC,
      PH_BCC2,
      PH_CLOSE
   } phase_type;

   function automatic logic needs_esc(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage

// ===== sv/ifbs_req_if.sv =====
// ----------------------------------------------------------------------------
// ifbs_req_if
// Input channel: raw payload words with sequence bit and last mark.
// ----------------------------------------------------------------------------
interface ifbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       seq_bit;
   logic       last_in;

   modport source (output valid, output payload_byte, output seq_bit, output last_in,
                   input ready);
   modport sink   (input valid, input payload_byte, input seq_bit, input last_in,
                   output ready);
endinterface

// ===== sv/ifbs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ifbs_rsp_if
// Result channel: stuffed line bytes with end marks.
// ----------------------------------------------------------------------------
interface ifbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       last_out;
   logic       frame_end;

   modport source (output valid, output line_byte, output last_out, output frame_end,
                   input ready);
   modport sink   (input valid, input line_byte, input last_out, input frame_end,
                   output ready);
endinterface

// ===== sv/ifbs_front.sv =====
// ----------------------------------------------------------------------------
// ifbs_front
// Accepts input words, tracks frame state and the running BCC2, and pushes
// classified commands into the queue.
// ----------------------------------------------------------------------------
module ifbs_front (
   input  logic                  clock,
   input  logic                  reset,
   ifbs_req_if.sink              req,
   input  logic [7:0]            frame_address,
   input  logic                  q_full,
   output ifbs_pkg::cmd_slot_type q_push
);
   import ifbs_pkg::*;

   logic       in_frame_ff, in_frame_in;
   logic [7:0] parity_ff, parity_in;
   logic       accept;
   logic [7:0] parity_new;

   assign req.ready  = !q_full;
   assign accept     = req.valid && !q_full;
   assign parity_new = (in_frame_ff ? parity_ff : 8'h00) ^ req.payload_byte;

   always_comb begin
      q_push.valid    = accept;
      q_push.cmd.data = req.payload_byte;
      q_push.cmd.hdr  = !in_frame_ff;
      q_push.cmd.ctrl = req.seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
      q_push.cmd.addr = frame_address;
      q_push.cmd.last = req.last_in;
      q_push.cmd.bcc  = parity_new;
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      parity_in   = parity_ff;
      if (accept) begin
         in_frame_in = !req.last_in;
         parity_in   = req.last_in ? 8'h00 : parity_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         parity_ff   <= 8'h00;
      end else begin
         in_frame_ff <= in_frame_in;
         parity_ff   <= parity_in;
      end
   end

endmodule

// ===== sv/ifbs_queue.sv =====
// ----------------------------------------------------------------------------
// ifbs_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ifbs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ifbs_pkg::cmd_slot_type q_push,
   output logic                   q_full,
   output ifbs_pkg::cmd_slot_type q_head,
   input  logic                   q_pop
);
   import ifbs_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_full       = (count_ff == 2'd2);
   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.cmd   = entry_ff[rd_ptr_ff];

   assign do_push = q_push.valid && !q_full;
   assign do_pop  = q_pop && q_head.valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/ifbs_back.sv =====
// ----------------------------------------------------------------------------
// ifbs_back
// Walks each queued command through header (first word), stuffed data, stuffed
// BCC2 and closing flag (last word), one line byte per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
module ifbs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ifbs_pkg::cmd_slot_type q_head,
   output logic                   q_pop,
   ifbs_rsp_if.source             rsp
);
   import ifbs_pkg::*;

   phase_type  phase_ff, phase_in;
   phase_type  cur, nxt;
   logic       done;
   logic       load, emit;
   logic [7:0] byte_val;
   logic       end_val;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] line_byte_ff;
   logic       last_out_ff;
   logic       frame_end_ff;

   cmd_type cmd;
   assign cmd = q_head.cmd;

   assign load  = !rsp_valid_ff || rsp.ready;
   assign emit  = load && q_head.valid;
   assign q_pop = emit && done;

   // next state
   always_comb begin
      cur = phase_ff;
      if (phase_ff == PH_START) begin
         if (cmd.hdr)                 cur = PH_FLAG;
         else if (needs_esc(cmd.data)) cur = PH_DATA_ESC;
         else                         cur = PH_DATA;
      end
      nxt  = PH_START;
      done = 1'b0;
      case (cur)
         PH_FLAG:     nxt = PH_ADDR;
         PH_ADDR:     nxt = PH_CTRL;
         PH_CTRL:     nxt = PH_BCC1;
         PH_BCC1:     nxt = needs_esc(cmd.data) ? PH_DATA_ESC : PH_DATA;
         PH_DATA_ESC: nxt = PH_DATA;
         PH_DATA: begin
            if (cmd.last) nxt = needs_esc(cmd.bcc) ? PH_BCC2_ESC : PH_BCC2;
            else          done = 1'b1;
         end
         PH_BCC2_ESC: nxt = PH_BCC2;
         PH_BCC2:     nxt = PH_CLOSE;
         PH_CLOSE:    done = 1'b1;
         default:     done = 1'b1;
      endcase
      phase_in = phase_ff;
      if (emit) phase_in = done ? PH_START : nxt;
   end

   // outputs
   always_comb begin
      byte_val = FLAG_BYTE;
      end_val  = 1'b0;
      case (cur)
         PH_FLAG:     byte_val = FLAG_BYTE;
         PH_ADDR:     byte_val = cmd.addr;
         PH_CTRL:     byte_val = cmd.ctrl;
         PH_BCC1:     byte_val = cmd.addr ^ cmd.ctrl;
         PH_DATA_ESC: byte_val = ESC_BYTE;
         PH_DATA:     byte_val = needs_esc(cmd.data) ? (cmd.data ^ ESC_MASK) : cmd.data;
         PH_BCC2_ESC: byte_val = ESC_BYTE;
         PH_BCC2:     byte_val = needs_esc(cmd.bcc) ? (cmd.bcc ^ ESC_MASK) : cmd.bcc;
         PH_CLOSE: begin
            byte_val = FLAG_BYTE;
            end_val  = 1'b1;
         end
         default:     byte_val = FLAG_BYTE;
      endcase
   end

   assign rsp_valid_in = load ? q_head.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (emit) begin
         line_byte_ff <= byte_val;
         last_out_ff  <= done;
         frame_end_ff <= end_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.line_byte = line_byte_ff;
   assign rsp.last_out  = last_out_ff;
   assign rsp.frame_end = frame_end_ff;

endmodule

// ===== sv/info_frame_byte_stuffer.sv =====
// ----------------------------------------------------------------------------
// info_frame_byte_stuffer
// HDLC-style framer: header, escaped payload, XOR BCC2 and closing flag.
// Channels: req carries payload words (payload_byte, seq_bit, last_in);
// rsp carries line words (line_byte, last_out, frame_end). A word moves
// when valid and ready are both high at a rising clock edge. csr_wr_en
// writes csr_wr_data into the frame address register (reset 0x03).
// Each input word produces 1 to 9 line words: header 4 if it opens a frame,
// data 1 or 2, and on the last word BCC2 1 or 2 plus the closing flag.
// The first line word of an input passes from the queue to the output register
// when the back is idle; otherwise it waits for the words queued ahead of it.
// Sustained rate: one line word per cycle out of the back sequencer while rsp
// is not stalled. A two-entry queue lets the front accept while the back works
// and while rsp stalls; with rsp stalled, the queue fills and req.ready drops.
// Reset (synchronous) closes any open frame and empties the queue.
// ----------------------------------------------------------------------------
module info_frame_byte_stuffer (
   input  logic       clock,
   input  logic       reset,
   ifbs_req_if.sink   req,
   ifbs_rsp_if.source rsp,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import ifbs_pkg::*;

   logic [7:0]   frame_address_ff, frame_address_in;
   cmd_slot_type q_push;
   cmd_slot_type q_head;
   logic         q_full;
   logic         q_pop;

   assign frame_address_in = csr_wr_en ? csr_wr_data : frame_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_address_ff <= ADDR_RESET;
      end else begin
         frame_address_ff <= frame_address_in;
      end
   end

   ifbs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .frame_address (frame_address_ff),
      .q_full        (q_full),
      .q_push        (q_push)
   );

   ifbs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   ifbs_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .q_pop  (q_pop),
      .rsp    (rsp)
   );

endmodule

// ===== sv/ifbs_checker.sv =====
// ----------------------------------------------------------------------------
// ifbs_checker
// Port-level checks on the byte stuffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "info_frame_byte_stuffer_macros.svh"

module ifbs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_line_byte,
   input logic       rsp_last_out,
   input logic       rsp_frame_end
);
   import ifbs_pkg::*;

   `IFBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_line_byte) && $stable(rsp_last_out) && $stable(rsp_frame_end), "stalled rsp word changed")
   `IFBS_ASSERT_NOW(a_close_flag, clock, reset, rsp_valid && rsp_frame_end, (rsp_line_byte == FLAG_BYTE) && rsp_last_out, "frame end is not a closing flag")
   `IFBS_ASSERT_NOW(a_esc_not_last, clock, reset, rsp_valid && (rsp_line_byte == ESC_BYTE), !rsp_last_out && !rsp_frame_end, "escape word marked last")
   `IFBS_ASSERT_NOW(a_reset_idle, clock, reset, $past(reset), !rsp_valid, "rsp valid right after reset")

endmodule

bind info_frame_byte_stuffer ifbs_checker u_ifbs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_line_byte (rsp.line_byte),
   .rsp_last_out  (rsp.last_out),
   .rsp_frame_end (rsp.frame_end)
);

// ===== test/tb_info_frame_byte_stuffer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_info_frame_byte_stuffer
// Drives payload words into the framer, checks every line word against table
// gold bytes or a behavioral predictor (header, escaping, BCC2, closing flag).
// A directed table opens the run, then random frames of mixed length follow,
// with address writes in and between frames, random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_info_frame_byte_stuffer;
   import ifbs_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 360;
   localparam int DIR_ROWS     = 23;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       last_out;
      logic       frame_end;
   } line_word_type;

   typedef enum logic {ROW_WORD, ROW_ADDR} row_kind_type;

   // gold_n of zero means the row is checked against the predictor
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   data;
      logic         seq;
      logic         last;
      logic [3:0]   gold_n;
      logic [71:0]  gold;
   } dir_row_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   ifbs_req_if req_ch ();
   ifbs_rsp_if rsp_ch ();

   info_frame_byte_stuffer u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // framer state as the predictor sees it
   logic [7:0] addr_model;
   logic       frame_open;
   logic [7:0] bcc_run;
   logic [7:0] pred_bytes [0:8];
   int         pred_n;

   line_word_type line_words_due [$];
   int            mismatch_count = 0;
   int            quiet_cycles = 0;
   int            burst_left;
   int            rx_cyc = 0;

   dir_row_type dir_table [0:DIR_ROWS-1] = '{
      '{ROW_WORD, 8'h55, 1'b0, 1'b1, 4'd7, 72'h7E03000355557E},
      '{ROW_WORD, 8'h7E, 1'b1, 1'b1, 4'd9, 72'h7E0340437D5E7D5E7E},
      '{ROW_WORD, 8'h7D, 1'b0, 1'b1, 4'd9, 72'h7E0300037D5D7D5D7E},
      '{ROW_WORD, 8'h7D, 1'b1, 1'b0, 4'd6, 72'h7E0340437D5D},
      '{ROW_WORD, 8'h00, 1'b0, 1'b0, 4'd1, 72'h00},
      '{ROW_WORD, 8'hFF, 1'b1, 1'b0, 4'd1, 72'hFF},
      '{ROW_WORD, 8'h80, 1'b0, 1'b1, 4'd0, 72'h0},
      '{ROW_WORD, 8'h00, 1'b0, 1'b1, 4'd7, 72'h7E03000300007E},
      '{ROW_WORD, 8'hFF, 1'b1, 1'b1, 4'd7, 72'h7E034043FFFF7E},
      '{ROW_ADDR, 8'h7E, 1'b0, 1'b0, 4'd0, 72'h0},
      '{ROW_WORD, 8'h5E, 1'b1, 1'b0, 4'd0, 72'h0},
      '{ROW_ADDR, 8'h7D, 1'b0, 1'b0, 4'd0, 72'h0},
      '{ROW_WORD, 8'h20, 1'b0, 1'b1, 4'd0, 72'h0},
      '{ROW_WORD, 8'h3D, 1'b0, 1'b1, 4'd0, 72'h0},
      '{ROW_ADDR, 8'h3E, 1'b0, 1'b0, 4'd0, 72'h0},
      '{ROW_WORD, 8'h01, 1'b1, 1'b1, 4'd0, 72'h0},
      '{ROW_ADDR, 8'h00, 1'b0, 1'b0, 4'd0, 72'h0},
      '{ROW_WORD, 8'h7F, 1'b1, 1'b1, 4'd0, 72'h0},
      '{ROW_ADDR, 8'hFF, 1'b0, 1'b0, 4'd0, 72'h0},
      '{ROW_WORD, 8'h5E, 1'b0, 1'b0, 4'd0, 72'h0},
      '{ROW_WORD, 8'h7E, 1'b1, 1'b0, 4'd0, 72'h0},
      '{ROW_WORD, 8'h5D, 1'b0, 1'b1, 4'd0, 72'h0},
      '{ROW_ADDR, 8'h3D, 1'b0, 1'b0, 4'd0, 72'h0}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int new_burst();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
   endfunction

   function automatic logic [7:0] pick_address();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return FLAG_BYTE;
         3: return ESC_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_byte(input logic [7:0] b);
      pred_bytes[pred_n] = b;
      pred_n++;
   endtask

   task automatic add_stuffed(input logic [7:0] b);
      if (b == FLAG_BYTE || b == ESC_BYTE) begin
         add_byte(ESC_BYTE);
         add_byte(b ^ ESC_MASK);
      end else begin
         add_byte(b);
      end
   endtask

   // line bytes caused by one payload word; header bytes go out unescaped
   task automatic predict_line_bytes(input logic [7:0] data, input logic seq,
                                     input logic last);
      logic [7:0] ctrl;
      pred_n = 0;
      if (!frame_open) begin
         ctrl = seq ? CTRL_SEQ1 : CTRL_SEQ0;
         add_byte(FLAG_BYTE);
         add_byte(addr_model);
         add_byte(ctrl);
         add_byte(addr_model ^ ctrl);
         frame_open = 1'b1;
         bcc_run    = 8'h00;
      end
      add_stuffed(data);
      bcc_run = bcc_run ^ data;
      if (last) begin
         add_stuffed(bcc_run);
         add_byte(FLAG_BYTE);
         frame_open = 1'b0;
         bcc_run    = 8'h00;
      end
   endtask

   task automatic send_word(input logic [7:0] data, input logic seq, input logic last,
                            input logic [3:0] gold_n, input logic [71:0] gold);
      line_word_type w;
      int            n;
      req_ch.valid        <= 1'b1;
      req_ch.payload_byte <= data;
      req_ch.seq_bit      <= seq;
      req_ch.last_in      <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_line_bytes(data, seq, last);
      n = (gold_n != 0) ? int'(gold_n) : pred_n;
      for (int i = 0; i < n; i++) begin
         w.line_byte = (gold_n != 0) ? gold[8*(n-1-i) +: 8] : pred_bytes[i];
         w.last_out  = (i == n - 1);
         w.frame_end = last && (i == n - 1);
         line_words_due.push_back(w);
      end
      if (burst_left <= 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = new_burst();
      end else begin
         burst_left--;
      end
   endtask

   // only written once every line word is out
   task automatic write_address(input logic [7:0] a);
      req_ch.valid <= 1'b0;
      while (line_words_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= a;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      addr_model = a;
   endtask

   initial begin
      int         frame_len;
      int         items;
      logic [7:0] d;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 8'h00;
      req_ch.valid        = 1'b0;
      req_ch.payload_byte = 8'h00;
      req_ch.seq_bit      = 1'b0;
      req_ch.last_in      = 1'b0;
      addr_model          = ADDR_RESET;
      frame_open          = 1'b0;
      bcc_run             = 8'h00;
      burst_left          = new_burst();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[r]) begin
         if (dir_table[r].kind == ROW_ADDR) begin
            write_address(dir_table[r].data);
         end else begin
            send_word(dir_table[r].data, dir_table[r].seq, dir_table[r].last,
                      dir_table[r].gold_n, dir_table[r].gold);
         end
      end

      items = 0;
      while (items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) write_address(pick_address());
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: frame_len = $urandom_range(1, 4);
            6, 7, 8:          frame_len = $urandom_range(5, 12);
            default:          frame_len = $urandom_range(13, 40);
         endcase
         for (int k = 0; k < frame_len; k++) begin
            // address change inside an open frame applies at the next header
            if (k > 0 && $urandom_range(0, 39) == 0) write_address(pick_address());
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 3))
                  0: d = FLAG_BYTE;
                  1: d = ESC_BYTE;
                  2: d = FLAG_BYTE ^ ESC_MASK;
                  default: d = ESC_BYTE ^ ESC_MASK;
               endcase
            end else begin
               d = 8'($urandom_range(0, 255));
            end
            send_word(d, 1'($urandom_range(0, 1)), k == frame_len - 1, 4'd0, 72'h0);
            items++;
         end
      end

      req_ch.valid <= 1'b0;
      while (line_words_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // receiver stall pattern: open, random, toggling, long stalls
   always @(posedge clock) begin
      rx_cyc <= rx_cyc + 1;
      case (rx_cyc[8:7])
         2'd0: rsp_ch.ready <= 1'b1;
         2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_ch.ready <= rx_cyc[0] ^ rx_cyc[3];
         default: rsp_ch.ready <= (rx_cyc[3:0] >= 4'd11);
      endcase
   end

   always @(posedge clock) begin : line_check
      line_word_type exp_w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (line_words_due.size() == 0) begin
            $error("unexpected line word: line_byte %h", rsp_ch.line_byte);
            mismatch_count++;
         end else begin
            exp_w = line_words_due.pop_front();
            if (rsp_ch.line_byte !== exp_w.line_byte) begin
               $error("line_byte: expected %h, got %h", exp_w.line_byte, rsp_ch.line_byte);
               mismatch_count++;
            end
            if (rsp_ch.last_out !== exp_w.last_out) begin
               $error("last_out: expected %b, got %b", exp_w.last_out, rsp_ch.last_out);
               mismatch_count++;
            end
            if (rsp_ch.frame_end !== exp_w.frame_end) begin
               $error("frame_end: expected %b, got %b", exp_w.frame_end, rsp_ch.frame_end);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
